// ===== rtl/evad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evad_pkg
// Shared types, constants and the log2 table for the energy VAD.
// ----------------------------------------------------------------------------
package evad_pkg;

    localparam int MAX_FRAME_LEN  = 1024;
    localparam int LOG_TABLE_BITS = 8;
    localparam int TABLE_SIZE     = 1 << LOG_TABLE_BITS;
    localparam int ESUM_W         = 41;
    localparam int CNT_W          = $clog2(MAX_FRAME_LEN + 1);
    localparam int DCNT_W         = $clog2(ESUM_W);
    localparam int P_W            = $clog2(ESUM_W);
    localparam int LEVEL_FLOOR    = -30720;
    localparam int TEN_LOG10_2    = 197283;
    localparam int NEG_W          = 21;
    localparam int MAG_W          = 15;
    localparam int PADDR_W        = 5;

    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_ATTACK    = 3'd1;
    localparam logic [2:0] REG_RELEASE   = 3'd2;
    localparam logic [2:0] REG_INIT_NF   = 3'd3;
    localparam logic [2:0] REG_HANGOVER  = 3'd4;

    typedef logic [15:0] log_tab_t [TABLE_SIZE];

    // log2(1 + i/2^LOG_TABLE_BITS) in Q16, truncated squaring in Q2.30
    function automatic logic [15:0] log_entry(int unsigned i);
        logic [63:0] x;
        logic [15:0] r;
        x = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
        r = '0;
        for (int k = 0; k < 16; k++) begin
            x = (x * x) >> 30;
            r = {r[14:0], 1'b0};
            if (x >= (64'd1 << 31)) begin
                r[0] = 1'b1;
                x    = x >> 1;
            end
        end
        return r;
    endfunction

    function automatic log_tab_t build_log_tab();
        log_tab_t t;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            t[i] = log_entry(i);
        end
        return t;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();

    typedef struct packed {
        logic load_in;
        logic acc;
        logic div_start;
        logic div_step;
        logic norm_step;
        logic log_calc;
        logic mag_calc;
        logic lvl_calc;
        logic decide;
        logic update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic frame_end;
        logic div_last;
        logic norm_done;
    } sts_t;

endpackage

// ===== rtl/evad_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evad_dp
// Datapath: energy accumulation, serial divide, normalise, log, level floor, voice decision and noise floor update.
// ----------------------------------------------------------------------------
module evad_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  evad_pkg::cmd_t       cmd,
    output evad_pkg::sts_t       sts,
    input  logic signed [15:0]   s_sample,
    input  logic                 s_frame_end,
    input  logic signed [15:0]   thr_db,
    input  logic [15:0]          attack_coeff,
    input  logic [15:0]          release_coeff,
    input  logic [15:0]          hangover_frames,
    input  logic                 nf_load,
    input  logic signed [15:0]   nf_init,
    output logic                 m_voiced,
    output logic signed [15:0]   m_level_db,
    output logic signed [15:0]   m_noise_db
);
    import evad_pkg::*;

    logic signed [15:0] smp_reg;
    logic               end_reg;
    logic [ESUM_W-1:0]  esum_reg, esum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ESUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]   dvs_reg;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [P_W-1:0]     p_reg, p_next;
    logic [NEG_W-1:0]   neg_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic signed [15:0] level_reg;
    logic               voiced_reg;
    logic [15:0]        hang_reg, hang_next;
    logic signed [33:0] prod_reg;
    logic signed [15:0] nf_reg, nf_next;

    logic signed [31:0] sq;
    logic [ESUM_W:0]    esum_add;
    logic [CNT_W:0]     rem_sh;
    logic               q_zero;
    logic [LOG_TABLE_BITS-1:0] idx;
    logic signed [23:0] l2;
    logic [NEG_W-1:0]   neg_c;
    logic [38:0]        mag_prod;
    logic signed [16:0] lvl_neg;
    logic signed [15:0] lvl_c;
    logic signed [16:0] snr;
    logic               above;
    logic [15:0]        coeff;
    logic signed [34:0] t_rnd;
    logic signed [18:0] delta;
    logic signed [19:0] nf_sum;

    assign sq       = smp_reg * smp_reg;
    assign esum_add = {1'b0, esum_reg} + {{(ESUM_W - 30){1'b0}}, sq[30:0]};
    assign rem_sh   = {rem_reg[CNT_W-1:0], quo_reg[ESUM_W-1]};
    assign q_zero   = (quo_reg == '0) || (dvs_reg == '0);

    assign idx   = quo_reg[ESUM_W-2 -: LOG_TABLE_BITS];
    assign l2    = $signed({{(24 - P_W - 16){1'b0}}, p_reg, 16'b0})
                 + $signed({8'b0, LOG_TAB[idx]}) - 24'sd1966080;
    assign neg_c = l2[23] ? NEG_W'(-l2) : '0;

    assign mag_prod = 39'(neg_reg) * 39'(TEN_LOG10_2) + (39'd1 << 23);
    assign lvl_neg  = -$signed({2'b0, mag_reg});
    assign lvl_c    = (q_zero || lvl_neg < 17'(LEVEL_FLOOR)) ? 16'(LEVEL_FLOOR)
                                                             : lvl_neg[15:0];

    assign snr   = 17'(level_reg) - 17'(nf_reg);
    assign above = snr > 17'(thr_db);
    assign coeff = (level_reg < nf_reg) ? attack_coeff : release_coeff;

    assign t_rnd  = 35'(prod_reg) + 35'sd32768;
    assign delta  = 19'(t_rnd >>> 16);
    assign nf_sum = 20'(nf_reg) + 20'(delta);

    assign sts.frame_end = end_reg;
    assign sts.div_last  = (dcnt_reg == DCNT_W'(ESUM_W - 1));
    assign sts.norm_done = quo_reg[ESUM_W-1] || (quo_reg == '0);

    always_comb begin
        esum_next = esum_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dcnt_next = dcnt_reg;
        p_next    = p_reg;
        hang_next = hang_reg;
        nf_next   = nf_reg;
        if (cmd.acc && cnt_reg < CNT_W'(MAX_FRAME_LEN)) begin
            esum_next = esum_add[ESUM_W] ? '1 : esum_add[ESUM_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
        end
        if (cmd.div_start) begin
            quo_next  = esum_reg;
            rem_next  = '0;
            dcnt_next = '0;
            p_next    = P_W'(ESUM_W - 1);
        end
        if (cmd.div_step) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[ESUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[ESUM_W-2:0], 1'b0};
            end
            dcnt_next = dcnt_reg + 1'b1;
        end
        if (cmd.norm_step && !sts.norm_done) begin
            quo_next = {quo_reg[ESUM_W-2:0], 1'b0};
            p_next   = p_reg - 1'b1;
        end
        if (cmd.decide) begin
            if (above) begin
                hang_next = hangover_frames;
            end else if (hang_reg != '0) begin
                hang_next = hang_reg - 1'b1;
            end
        end
        if (cmd.update && !voiced_reg) begin
            if (nf_sum > 20'sd32767) begin
                nf_next = 16'sh7fff;
            end else if (nf_sum < -20'sd32768) begin
                nf_next = -16'sd32768;
            end else begin
                nf_next = nf_sum[15:0];
            end
        end
        if (cmd.out_load) begin
            esum_next = '0;
            cnt_next  = '0;
        end
        if (nf_load) begin
            nf_next = nf_init;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esum_reg <= '0;
            cnt_reg  <= '0;
            hang_reg <= '0;
            nf_reg   <= -16'sd15360;
            dcnt_reg <= '0;
        end else begin
            esum_reg <= esum_next;
            cnt_reg  <= cnt_next;
            hang_reg <= hang_next;
            nf_reg   <= nf_next;
            dcnt_reg <= dcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        p_reg   <= p_next;
        if (cmd.load_in) begin
            smp_reg <= s_sample;
            end_reg <= s_frame_end;
        end
        if (cmd.div_start) begin
            dvs_reg <= cnt_reg;
        end
        if (cmd.log_calc) begin
            neg_reg <= neg_c;
        end
        if (cmd.mag_calc) begin
            mag_reg <= mag_prod[38:24];
        end
        if (cmd.lvl_calc) begin
            level_reg <= lvl_c;
        end
        if (cmd.decide) begin
            voiced_reg <= above || (hang_reg != '0);
            prod_reg   <= snr * $signed({1'b0, coeff});
        end
        if (cmd.out_load) begin
            m_voiced   <= voiced_reg;
            m_level_db <= level_reg;
            m_noise_db <= nf_reg;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_FRAME_LEN))
        else $error("sample count beyond frame limit");
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step && dvs_reg != '0 |=> rem_reg < {1'b0, dvs_reg})
        else $error("divider remainder not below divisor");
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.lvl_calc |=> level_reg <= 16'sd0 && level_reg >= 16'(LEVEL_FLOOR))
        else $error("frame level out of range");

endmodule

// ===== rtl/evad_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evad_ctrl
// Sequencer for sample intake, the frame-end level computation, decision and output.
// ----------------------------------------------------------------------------
module evad_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output evad_pkg::cmd_t cmd,
    input  evad_pkg::sts_t sts
);
    import evad_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_ACC  = 11'b000_0000_0010,
        S_DIVI = 11'b000_0000_0100,
        S_DIV  = 11'b000_0000_1000,
        S_NORM = 11'b000_0001_0000,
        S_LOG  = 11'b000_0010_0000,
        S_MAG  = 11'b000_0100_0000,
        S_LVL  = 11'b000_1000_0000,
        S_DEC  = 11'b001_0000_0000,
        S_UPD  = 11'b010_0000_0000,
        S_OUT  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.load_in   = s_valid && s_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc    = 1'b1;
                state_next = sts.frame_end ? S_DIVI : S_IDLE;
            end
            S_DIVI: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = S_NORM;
            end
            S_NORM: begin
                cmd.norm_step = 1'b1;
                if (sts.norm_done) state_next = S_LOG;
            end
            S_LOG: begin
                cmd.log_calc = 1'b1;
                state_next   = S_MAG;
            end
            S_MAG: begin
                cmd.mag_calc = 1'b1;
                state_next   = S_LVL;
            end
            S_LVL: begin
                cmd.lvl_calc = 1'b1;
                state_next   = S_DEC;
            end
            S_DEC: begin
                cmd.decide = 1'b1;
                state_next = S_UPD;
            end
            S_UPD: begin
                cmd.update = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_valid_reg || m_ready)
        else $error("result overwritten before taken");
    a_accept_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_ACC)
        else $error("accepted beat not accumulated");
    a_div_to_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV && sts.div_last |=> state_reg == S_NORM)
        else $error("divide did not hand over to normalise");

endmodule

// ===== rtl/energy_vad_with_noise_floor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// energy_vad_with_noise_floor
// Frame energy VAD with adaptive noise floor and hangover; APB config regs.
// ----------------------------------------------------------------------------
// A beat without frame end passes accept (idle) and accumulate before the next.
// A frame-end beat runs after accept through accumulate, divide set-up, the
// serial divide, normalise, then log, scale, level, decision and floor
// update, and output load; input reopens after the output load, later still
// while an unread result holds the output.
// Reset (synchronous, aresetn low): register defaults, sums and hangover
// cleared, noise floor loaded with the -60 dB initial value.
module energy_vad_with_noise_floor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [15:0]            s_sample,
    input  logic                          s_frame_end,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_voiced,
    output logic signed [15:0]            m_level_db,
    output logic signed [15:0]            m_noise_db,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [evad_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import evad_pkg::*;

    cmd_t               cmd;
    sts_t               sts;
    logic signed [15:0] thr_reg;
    logic [15:0]        att_reg;
    logic [15:0]        rel_reg;
    logic signed [15:0] init_reg;
    logic [15:0]        hang_reg;
    logic               wr_en;
    logic [2:0]         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= 16'sd1536;
            att_reg  <= 16'd6554;
            rel_reg  <= 16'd655;
            init_reg <= -16'sd15360;
            hang_reg <= 16'd20;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_THRESHOLD: thr_reg  <= pwdata[15:0];
                REG_ATTACK:    att_reg  <= pwdata[15:0];
                REG_RELEASE:   rel_reg  <= pwdata[15:0];
                REG_INIT_NF:   init_reg <= pwdata[15:0];
                REG_HANGOVER:  hang_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_THRESHOLD: prdata = {16'b0, thr_reg};
            REG_ATTACK:    prdata = {16'b0, att_reg};
            REG_RELEASE:   prdata = {16'b0, rel_reg};
            REG_INIT_NF:   prdata = {16'b0, init_reg};
            REG_HANGOVER:  prdata = {16'b0, hang_reg};
            default:       prdata = '0;
        endcase
    end

    evad_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    evad_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_sample        (s_sample),
        .s_frame_end     (s_frame_end),
        .thr_db          (thr_reg),
        .attack_coeff    (att_reg),
        .release_coeff   (rel_reg),
        .hangover_frames (hang_reg),
        .nf_load         (wr_en && reg_idx == REG_INIT_NF),
        .nf_init         (pwdata[15:0]),
        .m_voiced        (m_voiced),
        .m_level_db      (m_level_db),
        .m_noise_db      (m_noise_db)
    );

endmodule
